FILE: hw/rtl/rfbr_pkg.sv
// Shared types and constants for the range-filtered broadcast router.
// Used by rfbr_match.sv and range_filtered_broadcast_router.sv; no dependencies.
package rfbr_pkg;

   // Default sizes handed to the top level
   localparam int MAX_NODES_DEF  = 64;
   localparam int COORD_BITS_DEF = 24;

   // Fixed field widths
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 6;
   localparam int POS_W   = 24;
   localparam int ID_W    = 32;
   localparam int RANGE_W = 23;
   localparam int SQ_W    = 2 * RANGE_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // Register map (word index taken from paddr[2])
   localparam logic [0:0] REG_COMM_RANGE = 1'b0;
   localparam logic [RANGE_W-1:0] COMM_RANGE_RESET = 23'd12800;

   // Result queue depth (power of two)
   localparam int FIFO_DEPTH = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_BCAST  = 2'd2,
      CMD_DIRECT = 2'd3
   } cmd_type;

   // Tag that travels with each scanned entry through the match pipeline
   typedef struct packed {
      logic             vld;
      logic             cand;
      logic [IDX_W-1:0] idx;
   } tag_type;

   // Match pipeline verdict
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } hit_type;

   // One result word
   typedef struct packed {
      logic [IDX_W-1:0] target;
      logic             found;
      logic             last;
   } rsp_type;

endpackage

FILE: hw/rtl/range_filtered_broadcast_router.sv
// Top level of the range-filtered broadcast router: node table, scan sequencer,
// result queue and configuration port. Depends on rfbr_pkg and rfbr_match.
//
// Usage:
//  - The req channel carries one command word: write node, clear node,
//    broadcast query or directed query. The rsp channel returns result words
//    (target_index, found, last); every command ends with a word marked last.
//  - Write and clear complete in the accept cycle, which also pushes their
//    single result word into the result queue.
//  - A query reads the sender entry, then scans the node memory one entry per
//    cycle while the queue has room, through a 3-stage match pipeline; the
//    node memory has a single read port. A directed query stops scanning at
//    its first match.
//  - Results go through an 8-word queue. When rsp is stalled the scan holds
//    issue until the queue has room for every entry in flight; req is stalled
//    from acceptance of a query until its last word is queued, and while the queue is full.
//  - Reset clears all present flags, the queue and the sequencer, and sets
//    comm_range to 50.0. Node positions and identities are not cleared.
//  - comm_range is written through the APB-style port at address 0.
module range_filtered_broadcast_router #(
   parameter int MAX_NODES  = rfbr_pkg::MAX_NODES_DEF,
   parameter int COORD_BITS = rfbr_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rfbr_pkg::CMD_W-1:0]         req_cmd,
   input  logic [rfbr_pkg::IDX_W-1:0]         req_node_index,
   input  logic signed [rfbr_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [rfbr_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [rfbr_pkg::POS_W-1:0]  req_pos_z,
   input  logic [rfbr_pkg::ID_W-1:0]          req_unit_id,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rfbr_pkg::IDX_W-1:0]         rsp_target_index,
   output logic                               rsp_found,
   output logic                               rsp_last,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rfbr_pkg::ADDR_W-1:0]        paddr,
   input  logic [rfbr_pkg::DATA_W-1:0]        pwdata,
   output logic [rfbr_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import rfbr_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int AW     = $clog2(MAX_NODES);
   localparam int MW     = 3 * CB + ID_W;
   localparam int PRES_N = (MAX_NODES < 64) ? MAX_NODES : 64;
   localparam int PW     = $clog2(PRES_N);
   localparam int FPW    = $clog2(FIFO_DEPTH);
   localparam int FCW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SRC  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // sequencer
   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [AW-1:0]      sidx_ff, sidx_in;
   logic [ID_W-1:0]    want_id_ff, want_id_in;
   logic [AW-1:0]      scan_ff, scan_in;
   logic               issue_done_ff, issue_done_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic signed [CB-1:0] src_x_ff, src_y_ff, src_z_ff;
   logic signed [CB-1:0] src_x_in, src_y_in, src_z_in;

   // node table
   logic [MW-1:0]      node_mem [MAX_NODES];
   logic [MW-1:0]      rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [MW-1:0]      wr_word;
   logic               present_ff [PRES_N];
   logic               pres_set, pres_clr;

   // match pipeline
   tag_type            p0_tag_ff, p0_tag_in;
   hit_type            hit;
   logic [1:0]         match_busy;
   logic [1:0]         inflight;
   logic signed [CB-1:0] ent_x, ent_y, ent_z;
   logic [ID_W-1:0]    ent_id;

   // result queue
   rsp_type            fifo_mem_ff [FIFO_DEPTH];
   logic [FPW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [FCW-1:0]     fifo_count_ff;
   logic               push, pop;
   rsp_type            push_data;
   rsp_type            head;
   logic               fifo_full;
   logic               credit_ok;

   // configuration
   logic [RANGE_W-1:0] comm_range_ff;
   logic               cfg_we;

   // request decode
   logic               req_acc;
   logic               idx_ok;
   logic               sender_present;
   logic               scan_present;
   logic               stop_issue;
   logic               take_hit;
   logic signed [CB-1:0] wr_x, wr_y, wr_z;

   // ---------------------------------------------------------------- config
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_COMM_RANGE);
   assign prdata = (paddr[2] == REG_COMM_RANGE) ? DATA_W'(comm_range_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         comm_range_ff <= COMM_RANGE_RESET;
      end else if (cfg_we) begin
         comm_range_ff <= pwdata[RANGE_W-1:0];
      end
   end

   // ---------------------------------------------------------------- decode
   assign fifo_full      = (fifo_count_ff == FCW'(FIFO_DEPTH));
   assign req_stall      = !((state_ff == ST_IDLE) && !fifo_full);
   assign req_acc        = req_valid && !req_stall;
   assign idx_ok         = int'(req_node_index) < MAX_NODES;
   assign sender_present = idx_ok && present_ff[PW'(req_node_index)];
   assign scan_present   = (int'(scan_ff) < PRES_N) && present_ff[PW'(scan_ff)];

   assign wr_x    = CB'(req_pos_x);
   assign wr_y    = CB'(req_pos_y);
   assign wr_z    = CB'(req_pos_z);
   assign wr_word = {req_unit_id, wr_z, wr_y, wr_x};

   assign mem_we   = req_acc && (cmd_type'(req_cmd) == CMD_WRITE) && idx_ok;
   assign pres_set = mem_we;
   assign pres_clr = req_acc && (cmd_type'(req_cmd) == CMD_CLEAR) && idx_ok;

   // ---------------------------------------------------------------- node memory
   assign rd_addr = (state_ff == ST_SCAN) ? scan_ff : AW'(req_node_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[AW'(req_node_index)] <= wr_word;
      end
      rd_data_ff <= node_mem[rd_addr];
   end

   // present flags: cleared by reset, one per addressable entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PRES_N; i++) begin
            present_ff[i] <= 1'b0;
         end
      end else if (pres_set) begin
         present_ff[PW'(req_node_index)] <= 1'b1;
      end else if (pres_clr) begin
         present_ff[PW'(req_node_index)] <= 1'b0;
      end
   end

   assign ent_x  = rd_data_ff[CB-1:0];
   assign ent_y  = rd_data_ff[2*CB-1:CB];
   assign ent_z  = rd_data_ff[3*CB-1:2*CB];
   assign ent_id = rd_data_ff[MW-1:3*CB];

   // ---------------------------------------------------------------- match
   rfbr_match #(
      .COORD_BITS (COORD_BITS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .tag_in     (p0_tag_ff),
      .ent_x      (ent_x),
      .ent_y      (ent_y),
      .ent_z      (ent_z),
      .ent_id     (ent_id),
      .src_x      (src_x_ff),
      .src_y      (src_y_ff),
      .src_z      (src_z_ff),
      .want_id    (want_id_ff),
      .bcast      (cmd_ff == CMD_BCAST),
      .comm_range (comm_range_ff),
      .hit        (hit),
      .busy       (match_busy)
   );

   assign inflight  = {1'b0, p0_tag_ff.vld} + match_busy;
   assign credit_ok = ((FCW+1)'(fifo_count_ff) + (FCW+1)'(inflight) + (FCW+1)'(1))
                      <= (FCW+1)'(FIFO_DEPTH);
   assign stop_issue = issue_done_ff || ((cmd_ff == CMD_DIRECT) && pend_vld_ff);
   assign take_hit   = hit.hit && !((cmd_ff == CMD_DIRECT) && pend_vld_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sidx_in       = sidx_ff;
      want_id_in    = want_id_ff;
      scan_in       = scan_ff;
      issue_done_in = issue_done_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      src_x_in      = src_x_ff;
      src_y_in      = src_y_ff;
      src_z_in      = src_z_ff;
      p0_tag_in     = '0;
      push          = 1'b0;
      push_data     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_in     = cmd_type'(req_cmd);
               sidx_in    = AW'(req_node_index);
               want_id_in = req_unit_id;
               case (cmd_type'(req_cmd))
                  CMD_WRITE, CMD_CLEAR: begin
                     push      = 1'b1;
                     push_data = '{target: req_node_index, found: 1'b0, last: 1'b1};
                  end
                  CMD_BCAST: begin
                     if (sender_present) begin
                        state_in = ST_SRC;
                     end else begin
                        push      = 1'b1;
                        push_data = '{target: '0, found: 1'b0, last: 1'b1};
                     end
                  end
                  default: begin
                     if (idx_ok) begin
                        state_in = ST_SRC;
                     end else begin
                        push      = 1'b1;
                        push_data = '{target: '0, found: 1'b0, last: 1'b1};
                     end
                  end
               endcase
            end
         end
         ST_SRC: begin
            // capture sender position, start the scan at entry zero
            src_x_in      = ent_x;
            src_y_in      = ent_y;
            src_z_in      = ent_z;
            scan_in       = '0;
            issue_done_in = 1'b0;
            pend_vld_in   = 1'b0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            // issue one entry when the queue can absorb everything in flight
            if (!stop_issue && credit_ok) begin
               p0_tag_in.vld  = 1'b1;
               p0_tag_in.cand = scan_present && (scan_ff != sidx_ff);
               p0_tag_in.idx  = IDX_W'(scan_ff);
               scan_in        = scan_ff + AW'(1);
               if (scan_ff == AW'(MAX_NODES - 1)) begin
                  issue_done_in = 1'b1;
               end
            end
            // hold back the newest hit so the final one can carry last
            if (take_hit) begin
               if (pend_vld_ff) begin
                  push      = 1'b1;
                  push_data = '{target: pend_idx_ff, found: 1'b1, last: 1'b0};
               end
               pend_vld_in = 1'b1;
               pend_idx_in = hit.idx;
            end
            if (stop_issue && !p0_tag_ff.vld && (match_busy == 2'd0)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // close the command with the held word or a not-found word
            if (!fifo_full) begin
               push      = 1'b1;
               push_data = pend_vld_ff ?
                           '{target: pend_idx_ff, found: 1'b1, last: 1'b1} :
                           '{target: '0, found: 1'b0, last: 1'b1};
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         pend_vld_ff   <= 1'b0;
         p0_tag_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         pend_vld_ff   <= pend_vld_in;
         p0_tag_ff     <= p0_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sidx_ff     <= sidx_in;
      want_id_ff  <= want_id_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      src_x_ff    <= src_x_in;
      src_y_ff    <= src_y_in;
      src_z_ff    <= src_z_in;
   end

   // ---------------------------------------------------------------- result queue
   assign head             = fifo_mem_ff[rd_ptr_ff];
   assign rsp_valid        = (fifo_count_ff != '0);
   assign rsp_target_index = head.target;
   assign rsp_found        = head.found;
   assign rsp_last         = head.last;
   assign pop              = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FPW'(1);
         end
         fifo_count_ff <= fifo_count_ff + FCW'(push) - FCW'(pop);
      end
   end

   // ---------------------------------------------------------------- checks
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      push |-> (!fifo_full || pop))
      else $error("result queue overflow");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      p0_tag_ff.vld |-> (state_ff == ST_SCAN))
      else $error("scan entry issued outside a scan");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (inflight == 2'd0))
      else $error("query closed with entries still in the match pipeline");

   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DONE)))
      else $error("held result word outlived its query");

endmodule

FILE: hw/rtl/rfbr_match.sv
// Distance and identity match pipeline for the broadcast router scan.
// Depends on rfbr_pkg; fed by the node memory read port of the top level.
module rfbr_match #(
   parameter int COORD_BITS = rfbr_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rfbr_pkg::tag_type                 tag_in,
   input  logic signed [COORD_BITS-1:0]      ent_x,
   input  logic signed [COORD_BITS-1:0]      ent_y,
   input  logic signed [COORD_BITS-1:0]      ent_z,
   input  logic [rfbr_pkg::ID_W-1:0]         ent_id,
   input  logic signed [COORD_BITS-1:0]      src_x,
   input  logic signed [COORD_BITS-1:0]      src_y,
   input  logic signed [COORD_BITS-1:0]      src_z,
   input  logic [rfbr_pkg::ID_W-1:0]         want_id,
   input  logic                              bcast,
   input  logic [rfbr_pkg::RANGE_W-1:0]      comm_range,
   output rfbr_pkg::hit_type                 hit,
   output logic [1:0]                        busy
);
   import rfbr_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int CMPW = (CB + 1 > RANGE_W) ? CB + 1 : RANGE_W;

   // Magnitude of the difference of two coordinates
   function automatic logic [CB:0] absdiff(input logic signed [CB-1:0] a,
                                           input logic signed [CB-1:0] b);
      logic signed [CB:0] d;
      d = {a[CB-1], a} - {b[CB-1], b};
      return d[CB] ? $unsigned(-d) : $unsigned(d);
   endfunction

   logic [CB:0]        mag_x, mag_y, mag_z;
   logic               box_in;

   tag_type            p1_tag_ff;
   logic [RANGE_W-1:0] p1_dx_ff, p1_dy_ff, p1_dz_ff;
   logic               p1_box_ff, p1_idm_ff;

   tag_type            p2_tag_ff;
   logic [SQ_W-1:0]    p2_sx_ff, p2_sy_ff, p2_sz_ff;
   logic               p2_box_ff, p2_idm_ff;

   logic [SQ_W-1:0]    rsq_ff;
   logic [SUM_W-1:0]   dist_sum;

   // Stage 1: per-axis difference and box test against the radius
   always_comb begin
      mag_x  = absdiff(ent_x, src_x);
      mag_y  = absdiff(ent_y, src_y);
      mag_z  = absdiff(ent_z, src_z);
      box_in = (CMPW'(mag_x) <= CMPW'(comm_range)) &&
               (CMPW'(mag_y) <= CMPW'(comm_range)) &&
               (CMPW'(mag_z) <= CMPW'(comm_range));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff <= '0;
         p2_tag_ff <= '0;
      end else begin
         p1_tag_ff <= tag_in;
         p2_tag_ff <= p1_tag_ff;
      end
   end

   // Payload stages: differences fit the radius width once the box test passes
   always_ff @(posedge clock) begin
      p1_dx_ff  <= RANGE_W'(mag_x);
      p1_dy_ff  <= RANGE_W'(mag_y);
      p1_dz_ff  <= RANGE_W'(mag_z);
      p1_box_ff <= box_in;
      p1_idm_ff <= (ent_id == want_id);
      p2_sx_ff  <= SQ_W'(p1_dx_ff) * SQ_W'(p1_dx_ff);
      p2_sy_ff  <= SQ_W'(p1_dy_ff) * SQ_W'(p1_dy_ff);
      p2_sz_ff  <= SQ_W'(p1_dz_ff) * SQ_W'(p1_dz_ff);
      p2_box_ff <= p1_box_ff;
      p2_idm_ff <= p1_idm_ff;
      rsq_ff    <= SQ_W'(comm_range) * SQ_W'(comm_range);
   end

   // Stage 3: squared distance against squared radius, or identity match
   assign dist_sum = SUM_W'(p2_sx_ff) + SUM_W'(p2_sy_ff) + SUM_W'(p2_sz_ff);

   always_comb begin
      hit.idx = p2_tag_ff.idx;
      hit.hit = p2_tag_ff.vld && p2_tag_ff.cand &&
                (bcast ? (p2_box_ff && (dist_sum <= SUM_W'(rsq_ff))) : p2_idm_ff);
   end

   assign busy = {1'b0, p1_tag_ff.vld} + {1'b0, p2_tag_ff.vld};

endmodule

FILE: sim/tb_range_filtered_broadcast_router.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_filtered_broadcast_router: node table writes, clears,
// broadcast and directed queries, checked word by word against a behavioral node table.
// Depends on rfbr_pkg and the router RTL only.
module tb_range_filtered_broadcast_router;
   import rfbr_pkg::*;

   localparam int TABLE_SIZE     = MAX_NODES_DEF;
   localparam int TAIL_CYCLES    = TABLE_SIZE + 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 1_200_000;
   localparam int PHASES         = 6;
   localparam int WORDS_PER_PHASE = 60;
   localparam int DIR_ROWS       = 22;
   localparam logic [ADDR_W-1:0] RANGE_ADDR = {REG_COMM_RANGE, 2'b00};

   // One command word as offered on the req channel
   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] idx;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
      logic [ID_W-1:0]  uid;
   } cmd_word_type;

   // Directed row: command plus an optional hand-written single result
   typedef struct packed {
      cmd_word_type w;
      logic      fixed;
      rsp_type   exp;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [IDX_W-1:0]    req_node_index;
   logic [POS_W-1:0]    req_pos_x;
   logic [POS_W-1:0]    req_pos_y;
   logic [POS_W-1:0]    req_pos_z;
   logic [ID_W-1:0]     req_unit_id;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [IDX_W-1:0]    rsp_target_index;
   logic                rsp_found;
   logic                rsp_last;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Behavioral copy of the node table and the radius register
   bit                       node_live [TABLE_SIZE];
   logic signed [POS_W-1:0]  node_x    [TABLE_SIZE];
   logic signed [POS_W-1:0]  node_y    [TABLE_SIZE];
   logic signed [POS_W-1:0]  node_z    [TABLE_SIZE];
   logic [ID_W-1:0]          node_uid  [TABLE_SIZE];
   logic [RANGE_W-1:0]       radius;

   rsp_type     pending_routes [$];
   logic [ID_W-1:0] id_pool [8];
   int          cx, cy, cz;
   bit          tx_idle, rx_idle;
   int          hold_asked, hold_served;
   int          mismatch_count, cycle_count;
   int          words_sent, query_count, words_checked, widest_fanout, radius_writes;

   dir_row_type dir_table [DIR_ROWS] = '{
      // empty table: queries find nobody
      '{'{CMD_BCAST,  6'd0,  24'h0, 24'h0, 24'h0, 32'h0},        1'b1, '{6'd0,  1'b0, 1'b1}},
      '{'{CMD_DIRECT, 6'd5,  24'h0, 24'h0, 24'h0, 32'h0},        1'b1, '{6'd0,  1'b0, 1'b1}},
      // populate: origin, both coordinate extremes, range boundary cases
      '{'{CMD_WRITE,  6'd0,  24'h000000, 24'h000000, 24'h000000, 32'h1111_1111},
        1'b1, '{6'd0,  1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd63, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF},
        1'b1, '{6'd63, 1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd1,  24'h003200, 24'h000000, 24'h000000, 32'h0000_0022},
        1'b1, '{6'd1,  1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd2,  24'h000000, 24'h003201, 24'h000000, 32'h0000_0022},
        1'b1, '{6'd2,  1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd3,  24'h001E00, 24'h002800, 24'h000000, 32'h0000_0033},
        1'b1, '{6'd3,  1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd4,  24'h001E00, 24'h002800, 24'h000001, 32'h0000_0044},
        1'b1, '{6'd4,  1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd5,  24'h800000, 24'h800000, 24'h800000, 32'h1111_1111},
        1'b1, '{6'd5,  1'b0, 1'b1}},
      '{'{CMD_WRITE,  6'd6,  24'hFFCE00, 24'h000000, 24'h000000, 32'h0000_0000},
        1'b1, '{6'd6,  1'b0, 1'b1}},
      // broadcast from origin: exact radius on one axis and on a diagonal
      '{'{CMD_BCAST,  6'd0,  24'h0, 24'h0, 24'h0, 32'h0},        1'b0, '{6'd0, 1'b0, 1'b0}},
      // directed: sender skipped even when its own identity matches
      '{'{CMD_DIRECT, 6'd0,  24'h0, 24'h0, 24'h0, 32'h1111_1111}, 1'b0, '{6'd0, 1'b0, 1'b0}},
      '{'{CMD_DIRECT, 6'd5,  24'h0, 24'h0, 24'h0, 32'h1111_1111}, 1'b0, '{6'd0, 1'b0, 1'b0}},
      // directed from an absent sender still searches
      '{'{CMD_DIRECT, 6'd7,  24'h0, 24'h0, 24'h0, 32'h0000_0022}, 1'b0, '{6'd0, 1'b0, 1'b0}},
      '{'{CMD_DIRECT, 6'd0,  24'h0, 24'h0, 24'h0, 32'hFFFF_FFFF}, 1'b0, '{6'd0, 1'b0, 1'b0}},
      '{'{CMD_CLEAR,  6'd1,  24'h0, 24'h0, 24'h0, 32'h0},        1'b1, '{6'd1,  1'b0, 1'b1}},
      // broadcast from a cleared sender gives nothing
      '{'{CMD_BCAST,  6'd1,  24'h0, 24'h0, 24'h0, 32'h0},        1'b1, '{6'd0,  1'b0, 1'b1}},
      '{'{CMD_BCAST,  6'd0,  24'h0, 24'h0, 24'h0, 32'h0},        1'b0, '{6'd0, 1'b0, 1'b0}},
      '{'{CMD_BCAST,  6'd63, 24'h0, 24'h0, 24'h0, 32'h0},        1'b0, '{6'd0, 1'b0, 1'b0}},
      '{'{CMD_CLEAR,  6'd40, 24'h0, 24'h0, 24'h0, 32'h0},        1'b1, '{6'd40, 1'b0, 1'b1}},
      '{'{CMD_DIRECT, 6'd2,  24'h0, 24'h0, 24'h0, 32'hDEAD_BEEF}, 1'b1, '{6'd0,  1'b0, 1'b1}},
      '{'{CMD_BCAST,  6'd5,  24'h0, 24'h0, 24'h0, 32'h0},        1'b0, '{6'd0, 1'b0, 1'b0}}
   };

   range_filtered_broadcast_router dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_node_index   (req_node_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_unit_id      (req_unit_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target_index (rsp_target_index),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // Exact squared-distance test, per-axis reject first
   function automatic bit within_radius(int s, int t);
      longint r, dx, dy, dz;
      r  = longint'({1'b0, radius});
      dx = longint'(node_x[t]) - longint'(node_x[s]);
      dy = longint'(node_y[t]) - longint'(node_y[s]);
      dz = longint'(node_z[t]) - longint'(node_z[s]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      if (dx > r || dy > r || dz > r)
         return 1'b0;
      return (dx * dx + dy * dy + dz * dz) <= r * r;
   endfunction

   // Apply one command to the node table and queue the words it should produce
   task automatic route_word(input cmd_word_type w, input bit keep);
      rsp_type hits [$];
      int      s;
      s = int'(w.idx);
      case (w.cmd)
         CMD_WRITE: begin
            node_live[s] = 1'b1;
            node_x[s]    = w.x;
            node_y[s]    = w.y;
            node_z[s]    = w.z;
            node_uid[s]  = w.uid;
         end
         CMD_CLEAR: node_live[s] = 1'b0;
         CMD_BCAST: begin
            query_count++;
            if (node_live[s])
               for (int t = 0; t < TABLE_SIZE; t++)
                  if (t != s && node_live[t] && within_radius(s, t))
                     hits.insert(hits.size(), '{target: IDX_W'(t), found: 1'b1, last: 1'b0});
         end
         default: begin
            query_count++;
            for (int t = 0; t < TABLE_SIZE; t++)
               if (t != s && node_live[t] && node_uid[t] == w.uid) begin
                  hits.insert(hits.size(), '{target: IDX_W'(t), found: 1'b1, last: 1'b0});
                  break;
               end
         end
      endcase
      if (w.cmd == CMD_WRITE || w.cmd == CMD_CLEAR)
         hits.insert(hits.size(), '{target: w.idx, found: 1'b0, last: 1'b1});
      else if (hits.size() == 0)
         hits.insert(hits.size(), '{target: '0, found: 1'b0, last: 1'b1});
      else begin
         if (hits.size() > widest_fanout) widest_fanout = hits.size();
         hits[hits.size() - 1].last = 1'b1;
      end
      if (keep)
         foreach (hits[i]) pending_routes.insert(pending_routes.size(), hits[i]);
   endtask

   // Offer one word, after a random gap when tx_idle is set; hold it until the block takes it
   task automatic send_word(input cmd_word_type w, input bit fixed, input rsp_type fixed_word);
      int gap;
      gap = tx_idle ? int'($urandom_range(0, 6)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= w.cmd;
      req_node_index <= w.idx;
      req_pos_x      <= w.x;
      req_pos_y      <= w.y;
      req_pos_z      <= w.z;
      req_unit_id    <= w.uid;
      do @(posedge clock); while (req_stall);
      route_word(w, !fixed);
      if (fixed) pending_routes.insert(pending_routes.size(), fixed_word);
      words_sent++;
      @(negedge clock);
   endtask

   // Write the radius, then read it back; upper data bits carry junk
   task automatic set_radius(input logic [RANGE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RANGE_ADDR;
      pwdata  <= {9'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      radius = value;
      radius_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DATA_W'(value))
         note_mismatch($sformatf("comm_range read %h, wrote %h", prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Stop offering, wait out every pending word and the pipeline tail
   task automatic drain_routes();
      req_valid <= 1'b0;
      while (pending_routes.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   function automatic logic [IDX_W-1:0] pick_live();
      int live [$];
      for (int i = 0; i < TABLE_SIZE; i++)
         if (node_live[i]) live.insert(live.size(), i);
      if (live.size() == 0 || $urandom_range(0, 9) == 0)
         return IDX_W'($urandom_range(0, TABLE_SIZE - 1));
      return IDX_W'(live[$urandom_range(0, live.size() - 1)]);
   endfunction

   // Mostly near the phase cluster, sometimes exactly on it, sometimes anywhere
   function automatic logic [POS_W-1:0] rand_coord(int center);
      longint sp;
      int     roll;
      roll = int'($urandom_range(0, 9));
      sp   = longint'({1'b0, radius}) / 2 + 1;
      if (roll == 0) return POS_W'($urandom);
      if (roll < 3)  return POS_W'(center);
      return POS_W'(longint'(center) + longint'($urandom_range(0, 32'(2 * sp))) - sp);
   endfunction

   function automatic logic [ID_W-1:0] rand_uid();
      if ($urandom_range(0, 9) < 6) return id_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic cmd_word_type random_word();
      cmd_word_type w;
      int        roll;
      roll  = int'($urandom_range(0, 99));
      w.cmd = (roll < 35) ? CMD_WRITE : (roll < 45) ? CMD_CLEAR :
              (roll < 80) ? CMD_BCAST : CMD_DIRECT;
      w.idx = (w.cmd == CMD_BCAST || w.cmd == CMD_DIRECT) ? pick_live()
            : IDX_W'($urandom_range(0, TABLE_SIZE - 1));
      w.x   = rand_coord(cx);
      w.y   = rand_coord(cy);
      w.z   = rand_coord(cz);
      w.uid = rand_uid();
      if (w.cmd == CMD_DIRECT && $urandom_range(0, 9) < 7)
         w.uid = node_uid[pick_live()];
      return w;
   endfunction

   // Receiver: random stall per word when rx_idle is set, one long hold when asked
   initial begin
      int gap;
      rsp_stall   = 1'b0;
      hold_served = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_asked != hold_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served++;
         end else begin
            gap = rx_idle ? int'($urandom_range(0, 6)) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compare each accepted result word with the oldest pending one
   always @(posedge clock) begin : check_routes
      rsp_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_routes.size() == 0)
            note_mismatch($sformatf("word %0d/%0b/%0b with nothing pending",
                                    rsp_target_index, rsp_found, rsp_last));
         else begin
            want = pending_routes.pop_front();
            if (rsp_target_index !== want.target)
               note_mismatch($sformatf("target_index %0d, want %0d",
                                       rsp_target_index, want.target));
            if (rsp_found !== want.found)
               note_mismatch($sformatf("found %b, want %b", rsp_found, want.found));
            if (rsp_last !== want.last)
               note_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   initial begin
      cmd_word_type    w;
      logic [RANGE_W-1:0] next_radius;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_WRITE;
      req_node_index = '0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_pos_z      = '0;
      req_unit_id    = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      hold_asked     = 0;
      tx_idle        = 1'b1;
      rx_idle        = 1'b1;
      radius         = COMM_RANGE_RESET;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         node_live[i] = 1'b0;
         node_x[i]    = '0;
         node_y[i]    = '0;
         node_z[i]    = '0;
         node_uid[i]  = '0;
      end
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < 8; i++) id_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset radius
      foreach (dir_table[i])
         send_word(dir_table[i].w, dir_table[i].fixed, dir_table[i].exp);
      drain_routes();

      // Random phases, one radius setting each
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       next_radius = '0;
            1:       next_radius = '1;
            2:       next_radius = COMM_RANGE_RESET;
            3:       next_radius = RANGE_W'(1);
            4:       next_radius = RANGE_W'($urandom_range(256, 8192));
            default: next_radius = RANGE_W'($urandom);
         endcase
         set_radius(next_radius);
         cx      = int'($urandom_range(0, 1 << 21)) - (1 << 20);
         cy      = int'($urandom_range(0, 1 << 21)) - (1 << 20);
         cz      = int'($urandom_range(0, 1 << 21)) - (1 << 20);
         tx_idle = (p != 3);
         rx_idle = (p != 3 && p != 4);

         // Fill every entry at one point, then broadcast into a long receiver hold
         if (p == 0) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               w = '{CMD_WRITE, IDX_W'(i), POS_W'(cx), POS_W'(cx), POS_W'(cx), rand_uid()};
               send_word(w, 1'b0, '0);
            end
            hold_asked++;
            repeat (4) begin
               w     = random_word();
               w.cmd = CMD_BCAST;
               send_word(w, 1'b0, '0);
            end
         end
         repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
         drain_routes();
      end

      $display("Sent %0d command words (%0d queries) over %0d radius settings",
               words_sent, query_count, radius_writes + 1);
      $display("Checked %0d result words; widest broadcast reached %0d nodes",
               words_checked, widest_fanout);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/rfbr_pkg.sv
hw/rtl/rfbr_match.sv
hw/rtl/range_filtered_broadcast_router.sv
sim/tb_range_filtered_broadcast_router.sv
